### rtl/lzbd_pkg.sv
// Package for the LZ bitstream token decoder: token and phase types,
// sequencer states and the distance base tables. No dependencies.
package lzbd_pkg;

    localparam int SIZE_COUNT_BITS_DEF = 20;
    localparam int MAX_TOKENS          = 8;
    localparam int COUNT_BITS          = $clog2(MAX_TOKENS + 1);
    localparam logic [8:0]  END_CODE   = 9'h1ff;
    localparam logic [13:0] PREFIX_LEN = 14'h0d;

    typedef enum logic [1:0] {
        TK_LITERAL = 2'd0,
        TK_MATCH   = 2'd1,
        TK_END     = 2'd2,
        TK_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_FLAG, PH_LIT, PH_KIND, PH_WCLASS, PH_WDIST, PH_BCLASS, PH_BEXTRA,
        PH_BDIST, PH_L1, PH_L2, PH_L3, PH_L4, PH_UNARY, PH_LTAIL
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_RUN, ST_DRAIN
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  lit;
        logic [15:0] distance;
        logic [13:0] len;
    } tok_t;

    // Word match: distance field width per class.
    function automatic logic [3:0] word_width(input logic [1:0] cls);
        logic [3:0] w;
        case (cls)
            2'd0:    w = 4'd5;
            2'd1:    w = 4'd6;
            2'd2:    w = 4'd8;
            default: w = 4'd9;
        endcase
        return w;
    endfunction

    // Word match: distance base per class.
    function automatic logic [15:0] word_base(input logic [1:0] cls);
        logic [15:0] b;
        case (cls)
            2'd0:    b = 16'h0001;
            2'd1:    b = 16'h0021;
            2'd2:    b = 16'h0061;
            default: b = 16'h0161;
        endcase
        return b;
    endfunction

    // Block match: distance offset for a field width.
    function automatic logic [15:0] block_offset(input logic [3:0] w);
        logic [15:0] b;
        case (w)
            4'd14:   b = 16'h1fe1;
            4'd15:   b = 16'h5fe1;
            default: b = (16'd1 << w) - 16'd31;
        endcase
        return b;
    endfunction

endpackage

### rtl/lzbd_if.sv
// Channel interfaces of the LZ bitstream token decoder: byte input and token
// output, each valid/ready. Depends on lzbd_pkg.
interface lzbd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lzbd_tok_if;
    import lzbd_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  token_kind;
    logic [7:0]  literal_value;
    logic [15:0] match_distance;
    logic [13:0] match_length;
    logic        last_of_run;
    modport source (output valid, output token_kind, output literal_value,
                    output match_distance, output match_length, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input literal_value,
                    input match_distance, input match_length, input last_of_run,
                    output ready);
endinterface

### rtl/lz_bitstream_token_decoder.sv
// LZ bitstream token decoder, top level and only module.
// Depends on lzbd_pkg and the channel interfaces in lzbd_if.sv.
//
// Takes the compressed stream one byte per word on in_stream and emits
// literal, match, end and error tokens on out_tokens, last_of_run marking
// the final token caused by a byte. Control bits are taken MSB first from
// 32-bit little-endian words gathered from the stream; literal bytes come
// straight from the stream when the decoder asks for one. A single field
// extractor (bit window, barrel shift and refill merge) runs under a small
// sequencer: one field or token step per cycle while the output is not
// stalled. A byte is accepted, then the decode steps it releases run, then
// the run stops (no bits or byte to go on with, eight tokens reached, or
// the stream finished) and, when it released any token, the last token is
// handed over. The steps are bounded by the bits in the window and at most
// 8 tokens per byte; a stalled output adds its wait. in_stream.ready is low
// while a byte is being worked. Writing compressed_size (cfg_we) restarts
// decoding; write it only while the block is idle. Once an end or error
// token is emitted, further bytes are taken and dropped.
module lz_bitstream_token_decoder
    #(parameter int SIZE_COUNT_BITS = lzbd_pkg::SIZE_COUNT_BITS_DEF)
    (
        input  logic                       clk,
        input  logic                       rst_n,
        input  logic                       cfg_we,
        input  logic [SIZE_COUNT_BITS-1:0] cfg_wdata,
        lzbd_byte_if.sink                  in_stream,
        lzbd_tok_if.source                 out_tokens
    );
    import lzbd_pkg::*;

    localparam int CW = SIZE_COUNT_BITS + 1;   // consumed count may pass the size

    state_t                     state_reg, state_next;
    phase_t                     phase_reg, phase_next;
    logic [31:0]                window_reg, window_next;
    logic [5:0]                 rem_reg, rem_next;
    logic [23:0]                gather_reg, gather_next;
    logic [1:0]                 gidx_reg, gidx_next;
    logic [CW-1:0]              consumed_reg, consumed_next;
    logic [SIZE_COUNT_BITS-1:0] size_reg, size_next;
    logic [15:0]                pdist_reg, pdist_next;
    logic [13:0]                plen_reg, plen_next;
    logic [3:0]                 pstep_reg, pstep_next;
    logic [1:0]                 mclass_reg, mclass_next;
    logic                       fin_reg, fin_next;
    logic                       hbyte_reg, hbyte_next;
    logic [7:0]                 byte_reg, byte_next;
    logic                       hword_reg, hword_next;
    logic [31:0]                word_reg, word_next;
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic                       pend_valid_reg, pend_valid_next;
    tok_t                       pend_reg, pend_next;
    logic                       out_valid_reg, out_valid_next;
    tok_t                       out_reg, out_next;
    logic                       out_last_reg, out_last_next;

    logic        accept, out_free, can_iter, iterate, run_end;
    logic        it_end, it_tok;
    tok_t        tok;
    logic        room, lit_ok;
    logic [3:0]  n, lo;
    logic [14:0] v, v_fit, v_join, hi;
    logic        fits;

    // Handshake
    assign accept   = in_stream.valid && in_stream.ready;
    assign out_free = !out_valid_reg || out_tokens.ready;
    assign can_iter = !pend_valid_reg || out_free;
    assign iterate  = (state_reg == ST_RUN) && can_iter && !fin_reg
                      && (count_reg != COUNT_BITS'(MAX_TOKENS));
    assign run_end  = fin_reg || (count_reg == COUNT_BITS'(MAX_TOKENS))
                      || (can_iter && it_end);

    assign in_stream.ready = (state_reg == ST_IDLE);

    // Stream bounds
    assign room   = ({1'b0, consumed_reg} + (CW+1)'(4)) <= (CW+1)'(size_reg);
    assign lit_ok = consumed_reg < CW'(size_reg);

    // Field width of the current phase
    always_comb
    begin
        case (phase_reg)
            PH_KIND, PH_WCLASS: n = 4'd2;
            PH_WDIST:           n = word_width(mclass_reg);
            PH_BCLASS, PH_L3:   n = 4'd3;
            PH_BDIST:           n = pdist_reg[3:0];
            PH_L4:              n = 4'd4;
            PH_LTAIL:           n = pstep_reg;
            default:            n = 4'd1;
        endcase
        if (n == 4'd0)
        begin
            n = 4'd1;
        end
    end

    // Shared extractor: top bits of the window, or window tail merged with a new word
    assign fits   = rem_reg >= {2'b00, n};
    assign lo     = n - rem_reg[3:0];
    assign v_fit  = window_reg[31:17] >> (4'd15 - n);
    assign hi     = window_reg[31:17] >> (4'd15 - rem_reg[3:0]);
    assign v_join = (hi << lo) | (word_reg[31:17] >> (4'd15 - lo));
    assign v      = fits ? v_fit : v_join;

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !fin_reg)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (run_end)
                begin
                    state_next = pend_valid_next ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we)
        begin
            state_next = ST_IDLE;
        end
    end

    // Datapath and outputs
    always_comb
    begin
        phase_next      = phase_reg;
        window_next     = window_reg;
        rem_next        = rem_reg;
        gather_next     = gather_reg;
        gidx_next       = gidx_reg;
        consumed_next   = consumed_reg;
        size_next       = size_reg;
        pdist_next      = pdist_reg;
        plen_next       = plen_reg;
        pstep_next      = pstep_reg;
        mclass_next     = mclass_reg;
        fin_next        = fin_reg;
        hbyte_next      = hbyte_reg;
        byte_next       = byte_reg;
        hword_next      = hword_reg;
        word_next       = word_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_tokens.ready;
        it_end          = 1'b0;
        it_tok          = 1'b0;
        tok             = '{kind: TK_ERROR, lit: 8'd0, distance: 16'd0, len: 14'd0};

        // Take a byte: literal, or one quarter of the next control word
        if (state_reg == ST_IDLE && accept && !fin_reg)
        begin
            count_next = '0;
            hbyte_next = 1'b0;
            hword_next = 1'b0;
            if (phase_reg == PH_LIT)
            begin
                hbyte_next = 1'b1;
                byte_next  = in_stream.stream_byte;
            end
            else
            begin
                gidx_next = gidx_reg + 2'd1;
                case (gidx_reg)
                    2'd0: gather_next[7:0]   = in_stream.stream_byte;
                    2'd1: gather_next[15:8]  = in_stream.stream_byte;
                    2'd2: gather_next[23:16] = in_stream.stream_byte;
                    default:
                    begin
                        word_next     = {in_stream.stream_byte, gather_reg};
                        hword_next    = 1'b1;
                        gather_next   = '0;
                        consumed_next = consumed_reg + CW'(4);
                    end
                endcase
            end
        end

        // One decode step
        if (iterate)
        begin
            if (phase_reg == PH_LIT)
            begin
                if (!lit_ok)
                begin
                    it_tok   = 1'b1;
                    fin_next = 1'b1;
                end
                else if (!hbyte_reg)
                begin
                    it_end = 1'b1;
                end
                else
                begin
                    hbyte_next    = 1'b0;
                    consumed_next = consumed_reg + CW'(1);
                    it_tok        = 1'b1;
                    tok.kind      = TK_LITERAL;
                    tok.lit       = byte_reg;
                    phase_next    = PH_FLAG;
                end
            end
            else if (phase_reg == PH_UNARY && pstep_reg == 4'd7)
            begin
                pstep_next = 4'd14;
                plen_next  = '0;
                phase_next = PH_LTAIL;
            end
            else if (!fits && !hword_reg)
            begin
                // out of bits: wait for the next word, or fail past the size
                if (room)
                begin
                    it_end = 1'b1;
                end
                else
                begin
                    it_tok   = 1'b1;
                    fin_next = 1'b1;
                end
            end
            else
            begin
                if (fits)
                begin
                    window_next = window_reg << n;
                    rem_next    = rem_reg - {2'b00, n};
                end
                else
                begin
                    window_next = word_reg << lo;
                    rem_next    = 6'd32 - {2'b00, lo};
                    hword_next  = 1'b0;
                end
                if (fits && rem_next == 6'd0 && !room)
                begin
                    it_tok   = 1'b1;
                    fin_next = 1'b1;
                end
                else
                begin
                    tok.kind     = TK_MATCH;
                    tok.distance = pdist_reg;
                    case (phase_reg)
                        PH_FLAG: phase_next = v[0] ? PH_KIND : PH_LIT;
                        PH_KIND:
                        begin
                            if (v[1:0] == 2'd3)
                            begin
                                phase_next = PH_WCLASS;
                            end
                            else
                            begin
                                mclass_next = v[1:0];
                                phase_next  = PH_BCLASS;
                            end
                        end
                        PH_WCLASS:
                        begin
                            mclass_next = v[1:0];
                            phase_next  = PH_WDIST;
                        end
                        PH_WDIST:
                        begin
                            it_tok = 1'b1;
                            if (v == 15'(END_CODE))
                            begin
                                tok.kind     = TK_END;
                                tok.distance = '0;
                                fin_next     = 1'b1;
                            end
                            else
                            begin
                                tok.distance = word_base(mclass_reg) + {7'd0, v[8:0]};
                                tok.len      = 14'd2;
                                phase_next   = PH_FLAG;
                            end
                        end
                        PH_BCLASS:
                        begin
                            phase_next = PH_BDIST;
                            case (v[2:0])
                                3'd3:
                                begin
                                    pdist_next = 16'd8;
                                    phase_next = PH_BEXTRA;
                                end
                                3'd4:
                                begin
                                    pdist_next = 16'd10;
                                    phase_next = PH_BEXTRA;
                                end
                                3'd5:    pdist_next = 16'd12;
                                3'd6:    pdist_next = 16'd14;
                                3'd7:    pdist_next = 16'd15;
                                default: pdist_next = {13'd0, v[2:0]} + 16'd5;
                            endcase
                        end
                        PH_BEXTRA:
                        begin
                            pdist_next = pdist_reg + {15'd0, v[0]};
                            phase_next = PH_BDIST;
                        end
                        PH_BDIST:
                        begin
                            pdist_next   = block_offset(pdist_reg[3:0]) + {1'b0, v};
                            tok.distance = pdist_next;
                            if (mclass_reg != 2'd0)
                            begin
                                it_tok     = 1'b1;
                                tok.len    = {12'd0, mclass_reg} + 14'd2;
                                phase_next = PH_FLAG;
                            end
                            else
                            begin
                                phase_next = PH_L1;
                            end
                        end
                        PH_L1: phase_next = v[0] ? PH_L3 : PH_L2;
                        PH_L2:
                        begin
                            it_tok     = 1'b1;
                            tok.len    = {13'd0, v[0]} + 14'd5;
                            phase_next = PH_FLAG;
                        end
                        PH_L3:
                        begin
                            if (v[2:0] != 3'd0)
                            begin
                                it_tok     = 1'b1;
                                tok.len    = {11'd0, v[2:0]} + 14'd6;
                                phase_next = PH_FLAG;
                            end
                            else
                            begin
                                phase_next = PH_L4;
                            end
                        end
                        PH_L4:
                        begin
                            if (v[3:0] != 4'd0)
                            begin
                                it_tok     = 1'b1;
                                tok.len    = {10'd0, v[3:0]} + 14'd13;
                                phase_next = PH_FLAG;
                            end
                            else
                            begin
                                pstep_next = 4'd4;
                                plen_next  = PREFIX_LEN;
                                phase_next = PH_UNARY;
                            end
                        end
                        PH_UNARY:
                        begin
                            plen_next  = {plen_reg[12:0], 1'b0} + 14'd3;
                            pstep_next = pstep_reg + 4'd1;
                            if (v[0])
                            begin
                                phase_next = PH_LTAIL;
                            end
                        end
                        PH_LTAIL:
                        begin
                            it_tok     = 1'b1;
                            tok.len    = plen_reg + v[13:0];
                            phase_next = PH_FLAG;
                        end
                        default: phase_next = PH_FLAG;
                    endcase
                end
            end

            // Keep the newest token back until the run is known to go on
            if (it_tok)
            begin
                if (tok.kind == TK_ERROR)
                begin
                    tok = '{kind: TK_ERROR, lit: 8'd0, distance: 16'd0, len: 14'd0};
                end
                else if (tok.kind != TK_MATCH)
                begin
                    tok.distance = '0;
                end
                count_next      = count_reg + COUNT_BITS'(1);
                pend_valid_next = 1'b1;
                pend_next       = tok;
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    out_last_next  = 1'b0;
                end
            end
        end

        // Hand over the last token of the run
        if (state_reg == ST_DRAIN && out_free)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        // Restart on a size write
        if (cfg_we)
        begin
            size_next       = cfg_wdata;
            phase_next      = PH_FLAG;
            window_next     = '0;
            rem_next        = '0;
            gather_next     = '0;
            gidx_next       = '0;
            consumed_next   = '0;
            pdist_next      = '0;
            plen_next       = '0;
            pstep_next      = 4'd4;
            mclass_next     = '0;
            fin_next        = 1'b0;
            hbyte_next      = 1'b0;
            hword_next      = 1'b0;
            count_next      = '0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_FLAG;
            window_reg     <= '0;
            rem_reg        <= '0;
            gather_reg     <= '0;
            gidx_reg       <= '0;
            consumed_reg   <= '0;
            size_reg       <= SIZE_COUNT_BITS'(4);
            pdist_reg      <= '0;
            plen_reg       <= '0;
            pstep_reg      <= 4'd4;
            mclass_reg     <= '0;
            fin_reg        <= 1'b0;
            hbyte_reg      <= 1'b0;
            hword_reg      <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            rem_reg        <= rem_next;
            gather_reg     <= gather_next;
            gidx_reg       <= gidx_next;
            consumed_reg   <= consumed_next;
            size_reg       <= size_next;
            pdist_reg      <= pdist_next;
            plen_reg       <= plen_next;
            pstep_reg      <= pstep_next;
            mclass_reg     <= mclass_next;
            fin_reg        <= fin_next;
            hbyte_reg      <= hbyte_next;
            hword_reg      <= hword_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload holds, no reset
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        word_reg     <= word_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_tokens.valid          = out_valid_reg;
    assign out_tokens.token_kind     = out_reg.kind;
    assign out_tokens.literal_value  = out_reg.lit;
    assign out_tokens.match_distance = out_reg.distance;
    assign out_tokens.match_length   = out_reg.len;
    assign out_tokens.last_of_run    = out_last_reg;

endmodule

### rtl/lzbd_checker.sv
// Port-level checks for the LZ bitstream token decoder, with the bind that
// attaches them to the top level. Depends on lzbd_pkg.
module lzbd_checker
    (
        input logic        clk,
        input logic        rst_n,
        input logic        cfg_we,
        input logic        out_valid,
        input logic        out_ready,
        input logic [1:0]  out_kind,
        input logic [7:0]  out_lit,
        input logic [15:0] out_dist,
        input logic [13:0] out_len,
        input logic        out_last
    );
    import lzbd_pkg::*;

    logic done_reg;

    // Set once a terminating token is taken, clear on restart
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            done_reg <= 1'b0;
        end
        else if (out_valid && out_ready && (out_kind == TK_END || out_kind == TK_ERROR))
        begin
            done_reg <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token dropped while stalled");

    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == TK_END || out_kind == TK_ERROR) |-> out_last)
        else $error("terminating token not last of run");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_kind == TK_LITERAL || out_lit == 8'd0)
                   && (out_kind == TK_MATCH || (out_dist == 16'd0 && out_len == 14'd0)))
        else $error("unused token fields not zero");

    a_silent: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !out_valid)
        else $error("token after end of stream");

endmodule

bind lz_bitstream_token_decoder lzbd_checker u_lzbd_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .out_valid (out_tokens.valid),
        .out_ready (out_tokens.ready),
        .out_kind  (out_tokens.token_kind),
        .out_lit   (out_tokens.literal_value),
        .out_dist  (out_tokens.match_distance),
        .out_len   (out_tokens.match_length),
        .out_last  (out_tokens.last_of_run)
    );
